### rtl/spike_transfer_lag_histogram_macros.svh
// Assertion macros for the lag histogram RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef SPIKE_TRANSFER_LAG_HISTOGRAM_MACROS_SVH
`define SPIKE_TRANSFER_LAG_HISTOGRAM_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define STL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define STL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define STL_ASSERT_NOW(label, clk, rst, ante, cons)
`define STL_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/stl_pkg.sv
// Package for the spike transfer lag histogram: word types, codes, sizes.
// No dependencies.
package stl_pkg;

   localparam int RASTER_DEPTH = 4096;
   localparam int SPIKE_DEPTH  = 1024;
   localparam int MAX_LAGS     = 64;

   localparam int RASTER_AW = $clog2(RASTER_DEPTH);
   localparam int RLEN_W    = RASTER_AW + 1;
   localparam int SPIKE_AW  = $clog2(SPIKE_DEPTH);
   localparam int SCNT_W    = SPIKE_AW + 1;

   localparam int TIME_W = 16;
   localparam int STEP_W = 12;
   localparam int JIT_W  = 8;
   localparam int IDX_W  = 6;
   localparam int CNT_W  = 11;
   localparam int WIN_W  = TIME_W + 2;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [1:0] CMD_CLEAR   = 2'd0;
   localparam logic [1:0] CMD_RASTER  = 2'd1;
   localparam logic [1:0] CMD_SPIKE   = 2'd2;
   localparam logic [1:0] CMD_COMPUTE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_LAG_STEP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LAG_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_JITTER    = 2'd2;

   typedef struct packed {
      logic [1:0]        command;
      logic              raster_bit;
      logic [TIME_W-1:0] spike_time;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] lag_index;
      logic [CNT_W-1:0] lag_count;
      logic             last;
   } rsp_type;

endpackage

### rtl/spike_transfer_lag_histogram.sv
// Spike transfer lag histogram: prefix-count raster store, spike store and a
// sequencer that walks every stored spike for every lag. Uses stl_pkg.
// Load words keep busy low. A compute word holds busy while, for every lag, it
// steps fetch, window, clip and compare for each spike, then a strobe state.
// Results cannot stall. Synchronous active-high reset clears control state,
// load counts, lag limit and jitter, and sets the lag step to 1.
`include "spike_transfer_lag_histogram_macros.svh"

module spike_transfer_lag_histogram (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  stl_pkg::req_type                 req_data,
   output logic                             busy,
   output logic                             rsp_strobe,
   output stl_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [stl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [stl_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import stl_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FETCH = 3'd1;
   localparam logic [2:0] S_WIN   = 3'd2;
   localparam logic [2:0] S_CLIP  = 3'd3;
   localparam logic [2:0] S_CMP   = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic [STEP_W-1:0]       step_ff, limit_ff;
   logic [JIT_W-1:0]        jit_ff;
   logic [RLEN_W-1:0]       rlen_ff, rlen_in, ones_ff, ones_in;
   logic [SCNT_W-1:0]       scnt_ff, scnt_in;
   logic [SPIKE_AW-1:0]     sidx_ff, sidx_in;
   logic [IDX_W-1:0]        k_ff, k_in;
   logic [STEP_W-1:0]       d_ff, d_in;
   logic [STEP_W:0]         dn_ff, dn_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [WIN_W-1:0] lo_s_ff, lo_s_in, hi_s_ff, hi_s_in;
   logic                    hit_ok_ff, hit_ok_in, lo_zero_ff, lo_zero_in;

   // prefix store: entry i holds the ones count over raster indices 0..i
   logic [RLEN_W-1:0]       pre_mem [RASTER_DEPTH];
   logic [RLEN_W-1:0]       pre_hi_q_ff, pre_lo_q_ff;
   logic [TIME_W-1:0]       spk_mem [SPIKE_DEPTH];
   logic [TIME_W-1:0]       spk_q_ff;

   logic                    accept, rast_we, spk_we, last_w, hit;
   logic [STEP_W-1:0]       step_eff;
   logic [RASTER_AW-1:0]    hi_addr, lo_addr;
   logic signed [WIN_W-1:0] rlen_s, centre;
   logic [RLEN_W-1:0]       lo_val;

   assign accept   = start && !busy;
   assign busy     = (state_ff != S_IDLE);
   assign rast_we  = accept && (req_data.command == CMD_RASTER)
                     && (rlen_ff < RLEN_W'(RASTER_DEPTH));
   assign spk_we   = accept && (req_data.command == CMD_SPIKE)
                     && (scnt_ff < SCNT_W'(SPIKE_DEPTH));
   assign step_eff = (step_ff == '0) ? STEP_W'(1) : step_ff;
   assign last_w   = (k_ff == IDX_W'(MAX_LAGS - 1)) || (dn_ff > {1'b0, limit_ff});

   assign rlen_s = signed'(WIN_W'(rlen_ff));
   assign centre = signed'(WIN_W'(spk_q_ff)) - signed'(WIN_W'(d_ff)) - WIN_W'(1);

   // window clipped to the loaded raster
   always_comb begin
      if (hi_s_ff >= rlen_s) begin
         hi_addr = RASTER_AW'(rlen_ff - RLEN_W'(1));
      end else begin
         hi_addr = hi_s_ff[RASTER_AW-1:0];
      end
      if (lo_s_ff <= 0) begin
         lo_addr = '0;
      end else begin
         lo_addr = RASTER_AW'(lo_s_ff - WIN_W'(1));
      end
   end

   assign lo_val = lo_zero_ff ? '0 : pre_lo_q_ff;
   assign hit    = hit_ok_ff && (pre_hi_q_ff != lo_val);

   always_ff @(posedge clock) begin
      if (rast_we) begin
         pre_mem[rlen_ff[RASTER_AW-1:0]] <= ones_ff + RLEN_W'(req_data.raster_bit);
      end
      if (spk_we) begin
         spk_mem[scnt_ff[SPIKE_AW-1:0]] <= req_data.spike_time;
      end
      pre_hi_q_ff <= pre_mem[hi_addr];
      pre_lo_q_ff <= pre_mem[lo_addr];
      spk_q_ff    <= spk_mem[sidx_ff];
   end

   always_comb begin
      state_in   = state_ff;
      rlen_in    = rlen_ff;
      ones_in    = ones_ff;
      scnt_in    = scnt_ff;
      sidx_in    = sidx_ff;
      k_in       = k_ff;
      d_in       = d_ff;
      dn_in      = dn_ff;
      cnt_in     = cnt_ff;
      lo_s_in    = lo_s_ff;
      hi_s_in    = hi_s_ff;
      hit_ok_in  = hit_ok_ff;
      lo_zero_in = lo_zero_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.command)
                  CMD_CLEAR: begin
                     rlen_in = '0;
                     ones_in = '0;
                     scnt_in = '0;
                  end
                  CMD_RASTER: begin
                     if (rast_we) begin
                        rlen_in = rlen_ff + RLEN_W'(1);
                        ones_in = ones_ff + RLEN_W'(req_data.raster_bit);
                     end
                  end
                  CMD_SPIKE: begin
                     if (spk_we) begin
                        scnt_in = scnt_ff + SCNT_W'(1);
                     end
                  end
                  default: begin
                     k_in     = '0;
                     d_in     = '0;
                     dn_in    = {1'b0, step_eff};
                     cnt_in   = '0;
                     sidx_in  = '0;
                     state_in = (scnt_ff == '0) ? S_EMIT : S_FETCH;
                  end
               endcase
            end
         end
         S_FETCH: begin
            state_in = S_WIN;
         end
         S_WIN: begin
            lo_s_in  = centre - signed'(WIN_W'(jit_ff));
            hi_s_in  = centre + signed'(WIN_W'(jit_ff));
            state_in = S_CLIP;
         end
         S_CLIP: begin
            hit_ok_in  = (hi_s_ff >= 0) && (lo_s_ff < rlen_s) && (rlen_ff != '0);
            lo_zero_in = (lo_s_ff <= 0);
            state_in   = S_CMP;
         end
         S_CMP: begin
            if (hit && (cnt_ff != '1)) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if ({1'b0, sidx_ff} + SCNT_W'(1) == scnt_ff) begin
               state_in = S_EMIT;
            end else begin
               sidx_in  = sidx_ff + SPIKE_AW'(1);
               state_in = S_FETCH;
            end
         end
         S_EMIT: begin
            if (last_w) begin
               state_in = S_IDLE;
            end else begin
               k_in     = k_ff + IDX_W'(1);
               d_in     = dn_ff[STEP_W-1:0];
               dn_in    = dn_ff + {1'b0, step_eff};
               cnt_in   = '0;
               sidx_in  = '0;
               state_in = (scnt_ff == '0) ? S_EMIT : S_FETCH;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= STEP_W'(1);
         limit_ff <= '0;
         jit_ff   <= '0;
         rlen_ff  <= '0;
         ones_ff  <= '0;
         scnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         rlen_ff  <= rlen_in;
         ones_ff  <= ones_in;
         scnt_ff  <= scnt_in;
         if (csr_we) begin
            case (csr_index)
               REG_LAG_STEP:  step_ff  <= csr_wdata[STEP_W-1:0];
               REG_LAG_LIMIT: limit_ff <= csr_wdata[STEP_W-1:0];
               REG_JITTER:    jit_ff   <= csr_wdata[JIT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      sidx_ff    <= sidx_in;
      k_ff       <= k_in;
      d_ff       <= d_in;
      dn_ff      <= dn_in;
      cnt_ff     <= cnt_in;
      lo_s_ff    <= lo_s_in;
      hi_s_ff    <= hi_s_in;
      hit_ok_ff  <= hit_ok_in;
      lo_zero_ff <= lo_zero_in;
   end

   assign rsp_strobe         = (state_ff == S_EMIT);
   assign rsp_data.lag_index = k_ff;
   assign rsp_data.lag_count = cnt_ff;
   assign rsp_data.last      = last_w;

   `STL_ASSERT_NOW(a_strobe_busy, clock, reset, rsp_strobe, busy)
   `STL_ASSERT_NEXT(a_compute_busy, clock, reset,
      accept && (req_data.command == CMD_COMPUTE), busy)
   `STL_ASSERT_NEXT(a_more_lags, clock, reset, rsp_strobe && !rsp_data.last, busy)
   `STL_ASSERT_NEXT(a_run_done, clock, reset, rsp_strobe && rsp_data.last, !busy)
   `STL_ASSERT_NOW(a_count_bound, clock, reset, rsp_strobe,
      SCNT_W'(rsp_data.lag_count) <= scnt_ff)

endmodule

### test/tb_spike_transfer_lag_histogram.sv
`timescale 1ns / 100ps
// Testbench for spike_transfer_lag_histogram: a directed plan, then random load
// and compute sequences. Lag words are checked against a local predictor or a
// fixed count from the plan. Depends on stl_pkg and the RTL.
module tb_spike_transfer_lag_histogram;
   import stl_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam logic [11:0] PREDICTED = 12'hFFF;

   typedef enum bit {PUT_WORD, PUT_REGS} row_kind_type;

   // For PUT_REGS rows: a = lag step, b = lag limit, c = jitter.
   // want: the single lag count expected, or PREDICTED.
   typedef struct packed {
      row_kind_type kind;
      logic [1:0]   cmd;
      bit           rbit;
      bit [15:0]    stime;
      bit [12:0]    reps;
      bit           rnd;
      logic [11:0]  want;
      bit [11:0]    a;
      bit [11:0]    b;
      bit [11:0]    c;
   } plan_row_type;

   localparam plan_row_type PLAN [24] = '{
      '{PUT_WORD, CMD_COMPUTE, 0, 0,     1,    0, 0,         0,    0,    0},
      '{PUT_WORD, CMD_SPIKE,   0, 0,     1,    0, PREDICTED, 0,    0,    0},
      '{PUT_WORD, CMD_SPIKE,   0, 65535, 1,    0, PREDICTED, 0,    0,    0},
      '{PUT_WORD, CMD_COMPUTE, 0, 0,     1,    0, 0,         0,    0,    0},
      '{PUT_WORD, CMD_RASTER,  1, 0,     3,    0, PREDICTED, 0,    0,    0},
      '{PUT_WORD, CMD_SPIKE,   0, 1,     1,    0, PREDICTED, 0,    0,    0},
      '{PUT_WORD, CMD_COMPUTE, 0, 0,     1,    0, 1,         0,    0,    0},
      '{PUT_WORD, CMD_RASTER,  0, 0,     2,    0, PREDICTED, 0,    0,    0},
      '{PUT_WORD, CMD_CLEAR,   0, 0,     1,    0, PREDICTED, 0,    0,    0},
      '{PUT_WORD, CMD_COMPUTE, 0, 0,     1,    0, 0,         0,    0,    0},
      '{PUT_WORD, CMD_RASTER,  0, 0,     16,   1, PREDICTED, 0,    0,    0},
      '{PUT_WORD, CMD_SPIKE,   0, 40,    6,    1, PREDICTED, 0,    0,    0},
      '{PUT_REGS, CMD_CLEAR,   0, 0,     0,    0, PREDICTED, 0,    4095, 255},
      '{PUT_WORD, CMD_COMPUTE, 0, 0,     1,    0, PREDICTED, 0,    0,    0},
      '{PUT_REGS, CMD_CLEAR,   0, 0,     0,    0, PREDICTED, 4095, 4095, 0},
      '{PUT_WORD, CMD_COMPUTE, 0, 0,     1,    0, PREDICTED, 0,    0,    0},
      '{PUT_REGS, CMD_CLEAR,   0, 0,     0,    0, PREDICTED, 5,    63,   2},
      '{PUT_WORD, CMD_COMPUTE, 0, 0,     1,    0, PREDICTED, 0,    0,    0},
      '{PUT_WORD, CMD_CLEAR,   0, 0,     1,    0, PREDICTED, 0,    0,    0},
      '{PUT_WORD, CMD_RASTER,  0, 0,     12,   1, PREDICTED, 0,    0,    0},
      '{PUT_WORD, CMD_SPIKE,   0, 30,    6,    1, PREDICTED, 0,    0,    0},
      '{PUT_REGS, CMD_CLEAR,   0, 0,     0,    0, PREDICTED, 2000, 4095, 7},
      '{PUT_WORD, CMD_COMPUTE, 0, 0,     1,    0, PREDICTED, 0,    0,    0},
      '{PUT_WORD, CMD_CLEAR,   0, 0,     1,    0, PREDICTED, 0,    0,    0}
   };

   // receiver cannot stall; zero-gap phases add no random idle between words
   localparam int SEND_GAP_PCT [4] = '{0, 53, 0, 32};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   req_type                req_data = '0;
   logic                   busy;
   logic                   rsp_strobe;
   rsp_type                rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   spike_transfer_lag_histogram dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   bit [11:0]   step_reg = 12'd1;
   bit [11:0]   limit_reg = 12'd0;
   bit [7:0]    jitter_reg = 8'd0;
   bit          raster_bits [RASTER_DEPTH];
   int          raster_len = 0;
   bit [15:0]   spike_times [SPIKE_DEPTH];
   int          spike_total = 0;
   int          ones_below [RASTER_DEPTH+1];
   rsp_type     lag_counts_due [$];
   int          fails = 0;
   int          cycles = 0;

   task automatic predict_lag_counts();
      int step, nlags, d, centre, lo, hi, top, hits;
      rsp_type r;
      step = (step_reg == 0) ? 1 : int'(step_reg);
      nlags = int'(limit_reg) / step + 1;
      if (nlags > MAX_LAGS) nlags = MAX_LAGS;
      ones_below[0] = 0;
      for (int i = 0; i < raster_len; i++) ones_below[i+1] = ones_below[i] + raster_bits[i];
      top = raster_len - 1;
      for (int k = 0; k < nlags; k++) begin
         d = k * step;
         hits = 0;
         for (int s = 0; s < spike_total; s++) begin
            centre = int'(spike_times[s]) - d - 1;
            lo = centre - int'(jitter_reg);
            hi = centre + int'(jitter_reg);
            if (lo < 0) lo = 0;
            if (hi > top) hi = top;
            if (lo <= hi && ones_below[hi+1] != ones_below[lo]) hits++;
         end
         if (hits > 2047) hits = 2047;
         r.lag_index = IDX_W'(k);
         r.lag_count = CNT_W'(hits);
         r.last = (k + 1 == nlags);
         lag_counts_due.push_back(r);
      end
   endtask

   task automatic track_word(input req_type w);
      case (w.command)
         CMD_CLEAR: begin
            raster_len = 0;
            spike_total = 0;
         end
         CMD_RASTER: begin
            if (raster_len < RASTER_DEPTH) begin
               raster_bits[raster_len] = w.raster_bit;
               raster_len++;
            end
         end
         CMD_SPIKE: begin
            if (spike_total < SPIKE_DEPTH) begin
               spike_times[spike_total] = w.spike_time;
               spike_total++;
            end
         end
         default: predict_lag_counts();
      endcase
   endtask

   task automatic send_word(input req_type w);
      start <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy === 1'b1);
   endtask

   task automatic feed(input req_type w, input int gap_pct);
      send_word(w);
      track_word(w);
      if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic wait_quiet();
      start <= 1'b0;
      @(posedge clock);
      while (lag_counts_due.size() != 0 || busy === 1'b1) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_regs(input bit [11:0] step, input bit [11:0] limit,
                           input bit [11:0] jdata);
      wait_quiet();
      csr_we <= 1'b1;
      csr_index <= REG_LAG_STEP;
      csr_wdata <= step;
      @(posedge clock);
      step_reg = step;
      csr_index <= REG_LAG_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      limit_reg = limit;
      csr_index <= REG_JITTER;
      csr_wdata <= jdata;
      @(posedge clock);
      jitter_reg = jdata[7:0];
      csr_we <= 1'b0;
   endtask

   task automatic random_regs();
      bit [11:0] step, limit;
      bit [7:0]  jit;
      case ($urandom_range(0, 9))
         0:       step = 0;
         9:       step = 4095;
         7, 8:    step = 12'($urandom_range(9, 4095));
         default: step = 12'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 9))
         0:       limit = 0;
         1:       limit = 4095;
         default: limit = 12'($urandom_range(0, 100));
      endcase
      case ($urandom_range(0, 9))
         0:       jit = 0;
         1:       jit = 255;
         default: jit = 8'($urandom_range(0, 6));
      endcase
      set_regs(step, limit, {4'($urandom), jit});
   endtask

   task automatic random_phase(input int gap_pct);
      int made, rlen, nspk, density;
      req_type w;
      random_regs();
      made = 0;
      while (made < 10) begin
         if ($urandom_range(0, 99) < 85) begin
            w = $bits(w)'($urandom);
            w.command = CMD_CLEAR;
            feed(w, gap_pct);
            rlen = $urandom_range(0, 12);
            nspk = $urandom_range(0, 6);
            density = $urandom_range(0, 100);
            for (int k = 0; k < rlen; k++) begin
               w = $bits(w)'($urandom);
               w.command = CMD_RASTER;
               w.raster_bit = ($urandom_range(0, 99) < density);
               feed(w, gap_pct);
            end
            for (int k = 0; k < nspk; k++) begin
               w = $bits(w)'($urandom);
               w.command = CMD_SPIKE;
               if ($urandom_range(0, 9) != 0) w.spike_time = 16'($urandom_range(0, rlen + 20));
               feed(w, gap_pct);
            end
            w.command = CMD_COMPUTE;
            feed(w, gap_pct);
            made += rlen + nspk + 2;
            if ($urandom_range(0, 99) < 30) begin
               random_regs();
               feed(w, gap_pct);
               made++;
            end else if ($urandom_range(0, 99) < 25) begin
               wait_quiet();
            end
         end else begin
            repeat ($urandom_range(1, 3)) begin
               w = $bits(w)'($urandom);
               feed(w, gap_pct);
               made++;
            end
         end
      end
   endtask

   always @(posedge clock) begin : check_lags
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (lag_counts_due.size() == 0) begin
            $error("unexpected lag word: index %0d count %0d", rsp_data.lag_index,
                   rsp_data.lag_count);
            fails++;
         end else begin
            want = lag_counts_due.pop_front();
            if (rsp_data.lag_index !== want.lag_index) begin
               $error("lag_index: expected %0d, actual %0d", want.lag_index, rsp_data.lag_index);
               fails++;
            end
            if (rsp_data.lag_count !== want.lag_count) begin
               $error("lag_count: expected %0d, actual %0d", want.lag_count, rsp_data.lag_count);
               fails++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_data.last);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      req_type w;
      rsp_type fixed;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (PLAN[i]) begin
         if (PLAN[i].kind == PUT_REGS) begin
            set_regs(PLAN[i].a, PLAN[i].b, PLAN[i].c);
         end else begin
            for (int r = 0; r < PLAN[i].reps; r++) begin
               w.command = PLAN[i].cmd;
               w.raster_bit = PLAN[i].rnd ? 1'($urandom) : PLAN[i].rbit;
               w.spike_time = PLAN[i].rnd ? 16'($urandom_range(0, PLAN[i].stime)) : PLAN[i].stime;
               send_word(w);
               if (PLAN[i].want != PREDICTED) begin
                  fixed.lag_index = '0;
                  fixed.lag_count = PLAN[i].want[CNT_W-1:0];
                  fixed.last = 1'b1;
                  lag_counts_due.push_back(fixed);
               end else begin
                  track_word(w);
               end
            end
         end
      end

      foreach (SEND_GAP_PCT[p]) random_phase(SEND_GAP_PCT[p]);

      wait_quiet();
      repeat (20) @(posedge clock);
      if (lag_counts_due.size() != 0) begin
         $error("%0d lag words never arrived", lag_counts_due.size());
         fails++;
      end
      if (fails == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
